>>> design/lcs_edit_script_engine_top_defines.svh
// Assertion macros shared by the checker.
`ifndef LCS_EDIT_SCRIPT_ENGINE_TOP_DEFINES_SVH
`define LCS_EDIT_SCRIPT_ENGINE_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LCS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LCS_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

>>> design/lcs_pkg.sv
package lcs_pkg;
    localparam int MAX_LEN     = 32;
    localparam int SYMBOL_BITS = 16;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int DIM         = MAX_LEN + 1;
    localparam int TAB_DEPTH   = DIM * DIM;
    localparam int TAB_W       = $clog2(TAB_DEPTH);
    localparam int PATH_DEPTH  = 2 * MAX_LEN;
    localparam int PATH_W      = $clog2(PATH_DEPTH);
    localparam int PLEN_W      = $clog2(PATH_DEPTH + 1);

    localparam logic [1:0] ACT_LEFT  = 2'd0;
    localparam logic [1:0] ACT_RIGHT = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    localparam logic [1:0] KIND_SAME    = 2'd0;
    localparam logic [1:0] KIND_ADDED   = 2'd1;
    localparam logic [1:0] KIND_REMOVED = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push_left;
        logic push_right;
        logic run_start;
        logic fill_init;
        logic fill_step;
        logic bt_init;
        logic bt_step;
        logic emit_init;
        logic emit_step;
        logic emit_none;
    } lcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic both_empty;
        logic fill_done;
        logic bt_done;
        logic emit_last;
    } lcs_sts_t;
endpackage

>>> design/lcs_edit_script_engine_top.sv
// Edit-script engine: push left (action 0) and right (action 1) symbols, one per
// cycle while idle, up to 32 each; action 2 runs the comparison. The score table
// fill covers (m+1)*(n+1) cells, each read from the registered table ports and
// then computed and written; backtrack takes up to m+n steps, and the script is
// emitted one word at a time, read from the path buffer and then loaded while the
// output register is free. Input is not accepted while a run is in progress.
module lcs_edit_script_engine_top
    import lcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // symbol[15:0]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // op_symbol[15:0], common_length[21:16], longer_length[27:22],
    // is_similar[28], dropped[29], zero[31:30]
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,   // op_kind[1:0]
    output logic        m_tlast    // is_last
);
    lcs_cmd_t    cmd;
    lcs_sts_t    sts;
    logic        out_free, out_load, out_similar, out_dropped, out_last;
    logic [1:0]  out_kind;
    logic [15:0] out_symbol;
    logic [5:0]  out_common, out_longer;

    lcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_action(s_tuser),
        .in_ready(s_tready), .out_free(out_free), .sts(sts), .cmd(cmd)
    );

    lcs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_symbol(SYMBOL_BITS'(s_tdata)),
        .sts(sts), .out_load(out_load), .out_kind(out_kind), .out_symbol(out_symbol),
        .out_common(out_common), .out_longer(out_longer), .out_similar(out_similar),
        .out_dropped(out_dropped), .out_last(out_last)
    );

    lcs_out_reg u_out (
        .clk(clk), .rst_n(rst_n), .load(out_load),
        .load_data({2'b00, out_dropped, out_similar, out_longer, out_common,
                    out_symbol}),
        .load_user(out_kind),
        .load_last(out_last), .out_free(out_free), .tvalid(m_tvalid),
        .tready(m_tready), .tdata(m_tdata), .tuser(m_tuser), .tlast(m_tlast)
    );
endmodule

>>> design/lcs_ctrl.sv
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_action,
    output logic       in_ready,
    input  logic       out_free,
    input  lcs_sts_t   sts,
    output lcs_cmd_t   cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_BT   = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequencing of push, fill, backtrack and emit phases.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.push_left  = (in_action == ACT_LEFT);
                    cmd.push_right = (in_action == ACT_RIGHT);
                    if (in_action == ACT_RUN)
                    begin
                        cmd.run_start = 1'b1;
                        cmd.fill_init = 1'b1;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                if (sts.both_empty)
                begin
                    state_next = S_WAIT;
                end
                else if (sts.fill_done)
                begin
                    cmd.bt_init = 1'b1;
                    state_next = S_BT;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            S_BT:
            begin
                if (sts.bt_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.bt_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> design/lcs_datapath.sv
module lcs_datapath
    import lcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcs_cmd_t               cmd,
    input  logic [SYMBOL_BITS-1:0] in_symbol,
    output lcs_sts_t               sts,
    output logic                   out_load,
    output logic [1:0]             out_kind,
    output logic [15:0]            out_symbol,
    output logic [5:0]             out_common,
    output logic [5:0]             out_longer,
    output logic                   out_similar,
    output logic                   out_dropped,
    output logic                   out_last
);
    // Sequence stores; read by registered ports only.
    logic [SYMBOL_BITS-1:0] left_mem [MAX_LEN];
    logic [SYMBOL_BITS-1:0] right_mem [MAX_LEN];
    logic [5:0]             tab_mem [TAB_DEPTH];
    logic [17:0]            path_mem [PATH_DEPTH];

    logic [CNT_W-1:0] left_count_reg, right_count_reg;
    logic             overflow_reg;
    logic [CNT_W-1:0] m_reg, n_reg;
    logic             drop_reg;
    logic [CNT_W-1:0] i_reg, j_reg;
    logic             phase_reg;
    logic             fill_done_reg, bt_done_reg;
    logic [PLEN_W-1:0] len_reg, k_reg;

    logic [SYMBOL_BITS-1:0] lsym_reg, rsym_reg;
    logic [5:0]             diag_reg, up_reg, left_reg;
    logic [5:0]             lcs_reg;

    logic [IDX_W-1:0] lrd_addr, rrd_addr;
    logic [TAB_W-1:0] ta_addr, tb_addr, tw_addr;
    logic [5:0]       ta_data, tb_data, tw_data;
    logic             tw_en;
    logic [5:0]       lcs_new;
    logic [CNT_W-1:0] longer;
    logic [10:0]      sim_lhs, sim_rhs;

    logic [17:0] path_rd;
    logic [1:0]  out_kind_bt;
    logic [15:0] out_sym_bt;
    logic        take_same, take_add;

    function automatic logic [TAB_W-1:0] tab_idx(input logic [CNT_W-1:0] i,
                                                 input logic [CNT_W-1:0] j);
        tab_idx = TAB_W'(i * DIM + j);
    endfunction

    assign sts.both_empty = (m_reg == '0) && (n_reg == '0) && !phase_reg && !fill_done_reg
                            && (i_reg == '0) && (j_reg == '0) && (len_reg == '0)
                            && (k_reg == '1);
    assign sts.fill_done  = fill_done_reg;
    assign sts.bt_done    = bt_done_reg;
    // The last word is loaded in the second half of its emission slot.
    assign sts.emit_last  = (k_reg == len_reg - PLEN_W'(1)) && phase_reg;

    // Pushes into the sequence stores.
    always_ff @(posedge clk)
    begin
        if (cmd.push_left && left_count_reg < CNT_W'(MAX_LEN))
        begin
            left_mem[left_count_reg[IDX_W-1:0]] <= in_symbol;
        end
        if (cmd.push_right && right_count_reg < CNT_W'(MAX_LEN))
        begin
            right_mem[right_count_reg[IDX_W-1:0]] <= in_symbol;
        end
        lsym_reg <= left_mem[lrd_addr];
        rsym_reg <= right_mem[rrd_addr];
    end

    // Score table memory: one write port, two read ports.
    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            tab_mem[tw_addr] <= tw_data;
        end
        ta_data <= tab_mem[ta_addr];
        tb_data <= tab_mem[tb_addr];
    end

    // Each cell has a read phase, then a compute and write phase.
    always_comb
    begin
        lrd_addr = IDX_W'(i_reg - CNT_W'(1));
        rrd_addr = IDX_W'(j_reg - CNT_W'(1));
        ta_addr  = tab_idx(i_reg - CNT_W'(1), j_reg - CNT_W'(1));
        tb_addr  = tab_idx(i_reg - CNT_W'(1), j_reg);
        tw_addr  = tab_idx(i_reg, j_reg);
        tw_en    = 1'b0;
        tw_data  = '0;
        lcs_new  = '0;
        if (cmd.fill_step && phase_reg)
        begin
            tw_en = 1'b1;
            if (i_reg == '0 || j_reg == '0)
            begin
                tw_data = '0;
            end
            else if (lsym_reg == rsym_reg)
            begin
                tw_data = ta_data + 6'd1;
            end
            else
            begin
                tw_data = (tb_data > left_reg) ? tb_data : left_reg;
            end
        end
        if (cmd.bt_step)
        begin
            ta_addr = tab_idx(i_reg, j_reg - CNT_W'(1));
            tb_addr = tab_idx(i_reg - CNT_W'(1), j_reg);
        end
        lcs_new = tw_data;
    end

    assign longer  = (m_reg > n_reg) ? m_reg : n_reg;
    assign sim_lhs = 11'(lcs_reg) * 11'd20;
    assign sim_rhs = 11'(longer) * 11'd7;

    // Path buffer: written during backtrack, read for emission.
    always_ff @(posedge clk)
    begin
        if (cmd.bt_step && phase_reg)
        begin
            path_mem[len_reg[PATH_W-1:0]] <= {out_kind_bt, out_sym_bt};
        end
        path_rd <= path_mem[PATH_W'(len_reg - k_reg - PLEN_W'(1))];
    end

    // Backtrack decision: match first, then insertion, else deletion.
    always_comb
    begin
        take_same = (i_reg != '0) && (j_reg != '0) && (lsym_reg == rsym_reg);
        take_add  = (j_reg != '0) && ((i_reg == '0) || (ta_data >= tb_data));
        if (take_same)
        begin
            out_kind_bt = KIND_SAME;
            out_sym_bt  = 16'(lsym_reg);
        end
        else if (take_add)
        begin
            out_kind_bt = KIND_ADDED;
            out_sym_bt  = 16'(rsym_reg);
        end
        else
        begin
            out_kind_bt = KIND_REMOVED;
            out_sym_bt  = 16'(lsym_reg);
        end
    end

    // Control counters of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            overflow_reg    <= 1'b0;
            m_reg <= '0;
            n_reg <= '0;
            drop_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            phase_reg <= 1'b0;
            fill_done_reg <= 1'b0;
            bt_done_reg <= 1'b0;
            len_reg <= '0;
            k_reg <= '0;
            lcs_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            if (cmd.push_left)
            begin
                if (left_count_reg < CNT_W'(MAX_LEN))
                    left_count_reg <= left_count_reg + CNT_W'(1);
                else
                    overflow_reg <= 1'b1;
            end
            if (cmd.push_right)
            begin
                if (right_count_reg < CNT_W'(MAX_LEN))
                    right_count_reg <= right_count_reg + CNT_W'(1);
                else
                    overflow_reg <= 1'b1;
            end
            if (cmd.run_start)
            begin
                m_reg <= left_count_reg;
                n_reg <= right_count_reg;
                drop_reg <= overflow_reg;
                left_count_reg <= '0;
                right_count_reg <= '0;
                overflow_reg <= 1'b0;
                i_reg <= '0;
                j_reg <= '0;
                phase_reg <= 1'b0;
                fill_done_reg <= 1'b0;
                len_reg <= '0;
                k_reg <= '1;
                lcs_reg <= '0;
            end
            if (cmd.fill_step)
            begin
                k_reg <= '0;
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    left_reg <= tw_data;
                    if (i_reg == m_reg && j_reg == n_reg)
                    begin
                        fill_done_reg <= 1'b1;
                        lcs_reg <= lcs_new;
                    end
                    else if (j_reg == n_reg)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                end
            end
            if (cmd.bt_init)
            begin
                i_reg <= m_reg;
                j_reg <= n_reg;
                phase_reg <= 1'b0;
                bt_done_reg <= 1'b0;
            end
            if (cmd.bt_step)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    len_reg <= len_reg + PLEN_W'(1);
                    if (take_same)
                    begin
                        i_reg <= i_reg - CNT_W'(1);
                        j_reg <= j_reg - CNT_W'(1);
                    end
                    else if (take_add)
                        j_reg <= j_reg - CNT_W'(1);
                    else
                        i_reg <= i_reg - CNT_W'(1);
                    if ((take_same && i_reg == CNT_W'(1) && j_reg == CNT_W'(1)) ||
                        (!take_same && take_add && i_reg == '0 && j_reg == CNT_W'(1)) ||
                        (!take_same && !take_add && j_reg == '0 && i_reg == CNT_W'(1)))
                        bt_done_reg <= 1'b1;
                end
            end
            if (cmd.emit_init)
            begin
                k_reg <= '0;
                phase_reg <= 1'b0;
            end
            if (cmd.emit_step)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                    k_reg <= k_reg + PLEN_W'(1);
            end
        end
    end

    // Each emitted word has a path read phase, then a load phase.
    always_comb
    begin
        out_load    = (cmd.emit_step && phase_reg) || cmd.emit_none;
        out_kind    = cmd.emit_none ? KIND_NONE : path_rd[17:16];
        out_symbol  = cmd.emit_none ? 16'd0 : path_rd[15:0];
        out_last    = cmd.emit_none || sts.emit_last;
        out_common  = out_last ? 6'(lcs_reg) : 6'd0;
        out_longer  = out_last ? 6'(longer) : 6'd0;
        out_similar = cmd.emit_none || (out_last && (sim_lhs >= sim_rhs));
        out_dropped = out_last && drop_reg;
    end
endmodule

>>> design/lcs_out_reg.sv
module lcs_out_reg
    import lcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [31:0] load_data,
    input  logic [1:0]  load_user,
    input  logic        load_last,
    output logic        out_free,
    output logic        tvalid,
    input  logic        tready,
    output logic [31:0] tdata,
    output logic [1:0]  tuser,
    output logic        tlast
);
    logic        valid_reg;
    logic [31:0] data_reg;
    logic [1:0]  user_reg;
    logic        last_reg;

    // A new word may be loaded when the register is empty or being drained.
    assign out_free = !valid_reg || tready;
    assign tvalid = valid_reg;
    assign tdata  = data_reg;
    assign tuser  = user_reg;
    assign tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
            user_reg <= load_user;
            last_reg <= load_last;
        end
    end
endmodule

>>> design/lcs_checker.sv
`include "lcs_edit_script_engine_top_defines.svh"
module lcs_checker
    import lcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    // Stalled output word holds.
    `LCS_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Summary fields appear only on the last word.
    `LCS_ASSERT_IMP(a_sum, clk, rst_n, m_tvalid && !m_tlast, m_tdata[31:16] == 16'd0)
    // Kind none is always a last word.
    `LCS_ASSERT_IMP(a_none, clk, rst_n, m_tvalid && m_tuser == KIND_NONE, m_tlast)
    // Input is refused while output words are pending from a run.
    `LCS_ASSERT_IMP(a_busy, clk, rst_n, m_tvalid && !m_tlast, !s_tready)
endmodule

bind lcs_edit_script_engine_top lcs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
);

>>> dv/lcs_edit_script_engine_top_test.sv
module lcs_edit_script_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    // Expected output word of the diff engine.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sym;
        logic [5:0]  common;
        logic [5:0]  longer;
        logic        similar;
        logic        dropped;
        logic        last;
    } edit_op_t;

    // One stimulus row; has_exp marks rows with a hand-written result.
    typedef struct {
        logic [1:0]  action;
        logic [15:0] sym;
        bit          has_exp;
        edit_op_t    exp_op;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    edit_op_t    pending_ops[$];
    int          error_count;
    bit          stim_done;

    // Predictor state.
    logic [15:0] left_seq[MAX_LEN];
    logic [15:0] right_seq[MAX_LEN];
    int          left_len;
    int          right_len;
    bit          overflow_flag;

    lcs_edit_script_engine_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Updates the sequences and queues the edit script a run produces.
    task automatic predict_edits(input logic [1:0] action, input logic [15:0] sym);
        int          score[DIM][DIM];
        edit_op_t    path[$];
        edit_op_t    op;
        int          i;
        int          j;
        int          common;
        int          longer;
        bit          similar;
        if (action == ACT_LEFT || action == ACT_RIGHT)
        begin
            if (action == ACT_LEFT && left_len < MAX_LEN)
            begin
                left_seq[left_len] = sym;
                left_len++;
            end
            else if (action == ACT_RIGHT && right_len < MAX_LEN)
            begin
                right_seq[right_len] = sym;
                right_len++;
            end
            else
                overflow_flag = 1'b1;
            return;
        end
        if (action != ACT_RUN)
            return;
        if (left_len == 0 && right_len == 0)
        begin
            op = '{KIND_NONE, 16'd0, 6'd0, 6'd0, 1'b1, overflow_flag, 1'b1};
            pending_ops.push_back(op);
            overflow_flag = 1'b0;
            return;
        end
        // Fill the score table.
        for (i = 0; i <= left_len; i++)
        begin
            for (j = 0; j <= right_len; j++)
            begin
                if (i == 0 || j == 0)
                    score[i][j] = 0;
                else if (left_seq[i-1] == right_seq[j-1])
                    score[i][j] = score[i-1][j-1] + 1;
                else
                    score[i][j] = (score[i-1][j] > score[i][j-1]) ?
                                  score[i-1][j] : score[i][j-1];
            end
        end
        common  = score[left_len][right_len];
        longer  = (left_len > right_len) ? left_len : right_len;
        similar = (20 * common >= 7 * longer);
        // Walk back, building the script from its end, each op pushed to the front.
        i = left_len;
        j = right_len;
        while (i > 0 || j > 0)
        begin
            op = '0;
            if (i > 0 && j > 0 && left_seq[i-1] == right_seq[j-1])
            begin
                op.kind = KIND_SAME;
                op.sym  = left_seq[i-1];
                i--;
                j--;
            end
            else if (j > 0 && (i == 0 || score[i][j-1] >= score[i-1][j]))
            begin
                op.kind = KIND_ADDED;
                op.sym  = right_seq[j-1];
                j--;
            end
            else
            begin
                op.kind = KIND_REMOVED;
                op.sym  = left_seq[i-1];
                i--;
            end
            path.push_front(op);
        end
        path[$].common  = common[5:0];
        path[$].longer  = longer[5:0];
        path[$].similar = similar;
        path[$].dropped = overflow_flag;
        path[$].last    = 1'b1;
        foreach (path[k])
            pending_ops.push_back(path[k]);
        left_len      = 0;
        right_len     = 0;
        overflow_flag = 1'b0;
    endtask

    // Sends one word, after an idle gap given by the caller.
    task automatic send_word(input logic [1:0] action, input logic [15:0] sym,
                             input int gap);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= sym;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_edits(action, sym);
    endtask

    // Stops offering words and waits until every expected word has come.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_ops.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        int        n;
        int        burst;
        int        alphabet;
        int        len;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_LEFT;
        error_count   = 0;
        stim_done     = 1'b0;
        left_len      = 0;
        right_len     = 0;
        overflow_flag = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty run, extreme symbols, ignored action, ties.
        r = '{ACT_RUN, 16'd0, 1'b1,
               '{KIND_NONE, 16'd0, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1}};
        rows.push_back(r);
        r = '{ACT_LEFT, 16'hFFFF, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RIGHT, 16'hFFFF, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RUN, 16'hFFFF, 1'b1,
               '{KIND_SAME, 16'hFFFF, 6'd1, 6'd1, 1'b1, 1'b0, 1'b1}};
        rows.push_back(r);
        r = '{2'd3, 16'h1234, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_LEFT, 16'h0000, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RUN, 16'h0, 1'b1,
               '{KIND_REMOVED, 16'h0000, 6'd0, 6'd1, 1'b0, 1'b0, 1'b1}};
        rows.push_back(r);
        r = '{ACT_RIGHT, 16'hA5A5, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RUN, 16'h0, 1'b1,
               '{KIND_ADDED, 16'hA5A5, 6'd0, 6'd1, 1'b0, 1'b0, 1'b1}};
        rows.push_back(r);
        r = '{ACT_LEFT, 16'h5A5A, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_LEFT, 16'h0001, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RIGHT, 16'h0001, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RIGHT, 16'h5A5A, 1'b0, '0};
        rows.push_back(r);
        r = '{ACT_RUN, 16'h0, 1'b0, '0};
        rows.push_back(r);
        foreach (rows[k])
        begin
            if (rows[k].has_exp)
            begin
                wait_drained();
                send_word(rows[k].action, rows[k].sym, 0);
                if (pending_ops.size() != 1 || pending_ops[0] != rows[k].exp_op)
                    report_mismatch("directed row", k, 0);
            end
            else
                send_word(rows[k].action, rows[k].sym, 0);
        end
        wait_drained();

        // Overflow both sequences at full length, then run.
        for (int k = 0; k < MAX_LEN + 2; k++)
        begin
            send_word(ACT_LEFT, 16'(k), 0);
            send_word(ACT_RIGHT, 16'(MAX_LEN - k), 0);
        end
        send_word(ACT_RUN, 16'h0, 0);
        n = 0;

        // Random comparisons: mostly short pairs over small alphabets.
        while (n < 85)
        begin
            alphabet = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 4);
            len = ($urandom_range(0, 9) == 0) ? 36 : 8;
            burst = $urandom_range(0, len);
            for (int k = 0; k < burst; k++)
            begin
                send_word(ACT_LEFT, 16'($urandom_range(0, alphabet)),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                n++;
            end
            burst = $urandom_range(0, len);
            for (int k = 0; k < burst; k++)
            begin
                send_word(ACT_RIGHT, 16'($urandom_range(0, alphabet)),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                n++;
            end
            if ($urandom_range(0, 9) == 0)
                send_word(2'd3, 16'($urandom()), 0);
            if ($urandom_range(0, 9) == 0)
                send_word(ACT_RUN, 16'($urandom()), 0);
            send_word(ACT_RUN, 16'($urandom()), $urandom_range(0, 3));
            n++;
            // Now and then, pause the sender until the script has drained.
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall pattern with one long hold-off.
    initial
    begin
        int cnt;
        m_tready   = 1'b0;
        cnt        = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cnt++;
            if (cnt >= 3000 && cnt < 3600)
                m_tready <= 1'b0;
            else if (cnt % 400 < 100)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Output checker.
    always @(posedge clk)
    begin
        edit_op_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ops.size() == 0)
                report_mismatch("unexpected word", m_tdata, 0);
            else
            begin
                want = pending_ops.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("op_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[15:0] != want.sym)
                    report_mismatch("op_symbol", 32'(m_tdata[15:0]), 32'(want.sym));
                if (m_tdata[21:16] != want.common)
                    report_mismatch("common_length", 32'(m_tdata[21:16]),
                                    32'(want.common));
                if (m_tdata[27:22] != want.longer)
                    report_mismatch("longer_length", 32'(m_tdata[27:22]),
                                    32'(want.longer));
                if (m_tdata[28] != want.similar)
                    report_mismatch("is_similar", 32'(m_tdata[28]), 32'(want.similar));
                if (m_tdata[29] != want.dropped)
                    report_mismatch("dropped", 32'(m_tdata[29]), 32'(want.dropped));
                if (m_tlast != want.last)
                    report_mismatch("is_last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // End of run.
    initial
    begin
        wait (stim_done);
        while (pending_ops.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (error_count == 0 && pending_ops.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
